// ----- rtl/hprm_pkg.sv -----
// Shared types and constants for the heartbeat peak rate meter.
// No dependencies; imported by the interfaces, the divider, the top level and the checker.
`timescale 1ns / 1ps

package hprm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_BITS     = 16;
    localparam int OUT_BITS      = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIV_STEP_BITS = $clog2(OUT_BITS);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [OUT_BITS-1:0]    t_word;

    localparam t_sample THRESHOLD_RESET    = t_sample'(2000);
    localparam t_time   MIN_INTERVAL_RESET = t_time'(600);
    localparam t_word   MS_PER_MINUTE      = t_word'(60000);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PEAK_LEVEL   = 1'b0,
        CFG_MIN_INTERVAL = 1'b1
    } t_cfg_addr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- rtl/hprm_in_if.sv -----
// Request channel of the heartbeat peak rate meter: sample, timestamp, restart.
// Depends on hprm_pkg.
`timescale 1ns / 1ps

interface hprm_in_if;
    import hprm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    t_time   time_ms;
    logic    restart;

    modport source (output valid, output sample, output time_ms, output restart, input ready);
    modport sink   (input valid, input sample, input time_ms, input restart, output ready);
endinterface

// ----- rtl/hprm_out_if.sv -----
// Result channel of the heartbeat peak rate meter: bpm and beat interval.
// Depends on hprm_pkg.
`timescale 1ns / 1ps

interface hprm_out_if;
    import hprm_pkg::*;

    logic  valid;
    logic  ready;
    t_word bpm;
    t_word interval_ms;

    modport source (output valid, output bpm, output interval_ms, input ready);
    modport sink   (input valid, input bpm, input interval_ms, output ready);
endinterface

// ----- rtl/heartbeat_peak_rate_meter.sv -----
// Top level of the heartbeat peak rate meter: peak window, beat timing, result register.
// Depends on hprm_pkg, hprm_in_if, hprm_out_if and hprm_div.
`timescale 1ns / 1ps

// Each request carries a 12-bit sample, a millisecond timestamp and a restart flag.
// A request that yields no beat result is accepted and the block stays ready.
// A beat that yields a result passes the window test, the bit-serial divider that
// forms 60000 / interval (one quotient bit per cycle), the divider's registered
// done flag and the load of the result register; the request side is held off for
// that time and for as long as an earlier result waits there.
// The user writes registers through the plain write port only while the block is
// idle; the block itself does not enforce this.
// Index 0 is the peak level (reset 2000), index 1 is min_interval_ms (reset 600).
module heartbeat_peak_rate_meter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  hprm_pkg::t_cfg_addr          i_cfg_addr,
    input  logic [hprm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    hprm_in_if.sink                      i_req,
    hprm_out_if.source                   o_rsp
);
    import hprm_pkg::*;

    t_state  r_state, n_state;
    t_sample r_threshold;
    t_time   r_min_interval;
    t_sample r_older;
    t_sample r_middle;
    logic [1:0] r_fill;
    t_time   r_last_beat;
    logic [1:0] r_beats;
    t_word   r_interval;
    logic    r_out_valid;
    t_word   r_out_bpm;
    t_word   r_out_ivl;

    logic    req_fire;
    logic    is_peak;
    t_time   interval;
    logic    is_beat;
    logic    has_result;
    logic    div_start;
    logic    div_done;
    t_word   div_quo;
    logic    out_load;

    assign req_fire = i_req.valid && i_req.ready;

    // window test on the incoming sample; the middle sample is the candidate
    assign is_peak = (r_fill == 2'd2) &&
                     (r_middle > r_older) &&
                     (r_middle > i_req.sample) &&
                     (r_middle > r_threshold) &&
                     (i_req.time_ms >= r_last_beat);
    assign interval   = i_req.time_ms - r_last_beat;
    assign is_beat    = is_peak && (interval > r_min_interval);
    assign has_result = req_fire && !i_req.restart && is_beat && (r_beats != 2'd0);

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (has_result) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RESET;
            r_min_interval <= MIN_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PEAK_LEVEL:   r_threshold    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sample window and beat state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_middle    <= '0;
            r_fill      <= '0;
            r_last_beat <= '0;
            r_beats     <= '0;
        end else if (req_fire) begin
            if (i_req.restart) begin
                r_older     <= '0;
                r_middle    <= '0;
                r_fill      <= '0;
                r_last_beat <= '0;
                r_beats     <= '0;
            end else begin
                r_older  <= r_middle;
                r_middle <= i_req.sample;
                if (r_fill != 2'd2) begin
                    r_fill <= r_fill + 2'd1;
                end
                if (is_beat) begin
                    r_last_beat <= i_req.time_ms;
                    if (r_beats != 2'd2) begin
                        r_beats <= r_beats + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_interval <= interval;
        end
    end

    hprm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (interval),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_bpm <= div_quo;
            r_out_ivl <= r_interval;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.bpm         = r_out_bpm;
    assign o_rsp.interval_ms = r_out_ivl;

endmodule

// ----- rtl/hprm_div.sv -----
// Bit-serial restoring divider: 60000 / divisor, one quotient bit per cycle.
// Depends on hprm_pkg.
`timescale 1ns / 1ps

module hprm_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [hprm_pkg::OUT_BITS-1:0] i_divisor,
    output logic                   o_done,
    output logic [hprm_pkg::OUT_BITS-1:0] o_quotient
);
    import hprm_pkg::*;

    logic                     r_busy, n_busy;
    logic [DIV_STEP_BITS-1:0] r_step, n_step;
    t_word                    r_rem, n_rem;
    t_word                    r_dvd, n_dvd;
    t_word                    r_quo, n_quo;
    t_word                    r_dsr, n_dsr;
    logic                     r_done, n_done;
    logic [OUT_BITS:0]        trial;
    logic [OUT_BITS:0]        diff;

    // shift next dividend bit into the partial remainder, subtract if it fits
    assign trial = {r_rem, r_dvd[OUT_BITS-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = MS_PER_MINUTE;
            n_quo  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[OUT_BITS-2:0], 1'b0};
            if (!diff[OUT_BITS]) begin
                n_rem = diff[OUT_BITS-1:0];
                n_quo = {r_quo[OUT_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial[OUT_BITS-1:0];
                n_quo = {r_quo[OUT_BITS-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == DIV_STEP_BITS'(OUT_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/hprm_checker.sv -----
// Port-level checks for the heartbeat peak rate meter, bound to the top level.
// Depends on hprm_pkg and heartbeat_peak_rate_meter.
`timescale 1ns / 1ps

module hprm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [hprm_pkg::OUT_BITS-1:0] i_rsp_bpm,
    input logic [hprm_pkg::OUT_BITS-1:0] i_rsp_ivl
);
    import hprm_pkg::*;

    // a waiting result holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_bpm) && $stable(i_rsp_ivl))
        else $error("result changed while stalled");

    // a beat interval is never zero and bpm never exceeds one per millisecond
    a_rsp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_ivl != '0) && (i_rsp_bpm <= MS_PER_MINUTE))
        else $error("result out of range");

    // the result goes through the serial divider: no result appears right after a request
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && !i_rsp_valid |=> !i_rsp_valid)
        else $error("result appeared one cycle after request");

    // nothing to report out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

endmodule

bind heartbeat_peak_rate_meter hprm_checker u_hprm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_bpm   (o_rsp.bpm),
    .i_rsp_ivl   (o_rsp.interval_ms)
);

// ----- verif/tb.sv -----
// Self-checking bench for heartbeat_peak_rate_meter: directed table, then random beat trains.
// Depends on hprm_pkg, hprm_in_if, hprm_out_if and the block under test.
`timescale 1ns / 1ps

module tb;
    import hprm_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 24;      // longer than one divide
    localparam int N_DIRECTED    = 29;
    localparam int N_PHASES      = 6;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        t_word bpm;
        t_word interval_ms;
    } t_beat_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // ROW_CFG rows carry the threshold in sample and the minimum interval in time_ms
    typedef struct {
        t_row_kind kind;
        t_sample   sample;
        t_time     time_ms;
        logic      restart;
        bit        pinned;
        bit        pin_beat;
        t_word     pin_bpm;
        t_word     pin_interval;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_addr i_cfg_addr;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    hprm_in_if  req_if ();
    hprm_out_if rsp_if ();

    heartbeat_peak_rate_meter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // beat detector copy: registers and state
    t_sample    model_threshold;
    t_time      model_min_gap;
    t_sample    win_older;
    t_sample    win_middle;
    logic [1:0] win_fill;
    t_time      last_beat_ms;
    logic [1:0] beats_counted;

    t_beat_result pending_beats[$];

    int  mismatches;
    int  n_requests;
    int  n_restarts;
    int  n_results;
    int  n_settings;
    int  cycle_count;
    bit  steady_flow;
    int  stream_ms;
    int  beat_ms;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_REQ, 12'd0,    16'd0,     1'b0, 1'b1, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd4095, 16'd10,    1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd700,   1'b0, 1'b1, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd2000, 16'd800,   1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd1300,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd2001, 16'd1300,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd1300,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd2001, 16'd1301,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd1301,  1'b0, 1'b1, 1'b1, 16'd99,    16'd601},
        '{ROW_REQ, 12'd4095, 16'd1500,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd4095, 16'd2500,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd2600,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd3000, 16'd2700,  1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd100,   1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd4095, 16'd65535, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd4000, 16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd601,   1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd4095, 16'd602,   1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd65535, 1'b0, 1'b1, 1'b1, 16'd0,     16'd64934},
        '{ROW_CFG, 12'd0,    16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd0,     1'b1, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd1,    16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd0,     1'b0, 1'b1, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd1,    16'd1,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd1,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd1,    16'd2,     1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
        '{ROW_REQ, 12'd0,    16'd2,     1'b0, 1'b1, 1'b1, 16'd60000, 16'd1}
    };

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void clear_beat_state();
        win_older     = '0;
        win_middle    = '0;
        win_fill      = '0;
        last_beat_ms  = '0;
        beats_counted = '0;
    endfunction

    // one sample through the three-sample window; returns 1 when a rate comes out
    function automatic bit predict_beat(input t_sample s, input t_time now, input logic rs,
                                        output t_beat_result r);
        t_time gap;
        bit    hit;
        hit = 1'b0;
        r   = '0;
        if (rs) begin
            clear_beat_state();
            return 1'b0;
        end
        if (win_fill >= 2 && win_middle > win_older && win_middle > s &&
            win_middle > model_threshold && now >= last_beat_ms) begin
            gap = now - last_beat_ms;
            if (gap > model_min_gap) begin
                if (beats_counted < 2) beats_counted++;
                if (beats_counted >= 2) begin
                    r.bpm         = MS_PER_MINUTE / gap;
                    r.interval_ms = gap;
                    hit           = 1'b1;
                end
                last_beat_ms = now;
            end
        end
        win_older  = win_middle;
        win_middle = s;
        if (win_fill < 2) win_fill++;
        return hit;
    endfunction

    task automatic send_req(input t_sample s, input t_time t, input logic rs,
                            output bit hit, output t_beat_result r);
        int idle;
        idle = 0;
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < 31) idle++;
            if (idle > 0 && $urandom_range(0, 9) == 0) idle += $urandom_range(5, 25);
        end
        @(negedge i_clk);
        if (idle > 0) begin
            req_if.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.sample  <= s;
        req_if.time_ms <= t;
        req_if.restart <= rs;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        hit = predict_beat(s, t, rs, r);
        n_requests++;
        if (rs) n_restarts++;
    endtask

    task automatic feed(input t_sample s, input int t, input logic rs);
        bit           hit;
        t_beat_result r;
        send_req(s, t_time'(t), rs, hit, r);
        if (hit) pending_beats.push_back(r);
    endtask

    // registers change only with the pipe empty
    task automatic load_settings(input t_sample thr, input t_time min_gap);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_PEAK_LEVEL;
        i_cfg_data <= CFG_DATA_BITS'(thr);
        @(negedge i_clk);
        i_cfg_addr <= CFG_MIN_INTERVAL;
        i_cfg_data <= min_gap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_threshold = thr;
        model_min_gap   = min_gap;
        n_settings++;
    endtask

    // mostly well-formed beat trains with random spacing around the minimum interval,
    // mixed with noise samples and restarts
    task automatic run_phase(input int n_items);
        int      start;
        int      roll;
        int      spacing;
        int      target;
        t_sample pk;
        start = n_requests;
        while (n_requests - start < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                feed(t_sample'($urandom), $urandom, 1'b1);
                stream_ms = $urandom_range(0, 200);
                beat_ms   = stream_ms;
            end else if (roll < 18) begin
                feed(t_sample'($urandom), $urandom_range(0, 1) ? int'($urandom_range(0, 65535))
                                                              : stream_ms, 1'b0);
            end else begin
                pk = (model_threshold < 4095) ? t_sample'($urandom_range(model_threshold + 1, 4095))
                                              : t_sample'(4095);
                spacing = int'(model_min_gap) + int'($urandom_range(0, 400)) - 40;
                if (spacing < 0) spacing = 0;
                repeat ($urandom_range(0, 3)) begin
                    stream_ms += $urandom_range(0, 8);
                    if (stream_ms > 65535) stream_ms = 65535;
                    feed(t_sample'($urandom_range(0, model_threshold)), stream_ms, 1'b0);
                end
                target = beat_ms + spacing;
                if (target < stream_ms) target = stream_ms;
                if (target > 65535) begin
                    if ($urandom_range(0, 1)) begin
                        target = 65535;
                    end else begin
                        // timestamps would wrap: start a new measurement
                        feed(t_sample'($urandom), $urandom, 1'b1);
                        stream_ms = $urandom_range(0, 200);
                        beat_ms   = stream_ms;
                        continue;
                    end
                end
                feed(t_sample'($urandom_range(0, pk - 1)), stream_ms, 1'b0);
                feed(pk, stream_ms, 1'b0);
                feed(t_sample'($urandom_range(0, pk - 1)), target, 1'b0);
                stream_ms = target;
                beat_ms   = target;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d rates still owed", cycle_count,
                 pending_beats.size());
        $display("tb NOT OK");
        $finish;
    end

    // result side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge i_clk) begin : rate_check
        t_beat_result want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch($sformatf("unexpected rate bpm=%0d interval=%0d",
                                        rsp_if.bpm, rsp_if.interval_ms));
            end else begin
                want = pending_beats.pop_front();
                n_results++;
                if (rsp_if.bpm !== want.bpm)
                    flag_mismatch($sformatf("bpm %0d, expected %0d (interval %0d)",
                                            rsp_if.bpm, want.bpm, want.interval_ms));
                if (rsp_if.interval_ms !== want.interval_ms)
                    flag_mismatch($sformatf("interval %0d, expected %0d",
                                            rsp_if.interval_ms, want.interval_ms));
            end
        end
    end

    initial begin
        bit           hit;
        t_beat_result got;
        t_beat_result pin;
        int           phase_thr [N_PHASES];
        int           phase_min [N_PHASES];
        int           phase_len [N_PHASES];

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_PEAK_LEVEL;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.sample  = '0;
        req_if.time_ms = '0;
        req_if.restart = 1'b0;
        steady_flow    = 1'b0;
        stream_ms      = 0;
        beat_ms        = 0;
        model_threshold = THRESHOLD_RESET;
        model_min_gap   = MIN_INTERVAL_RESET;
        clear_beat_state();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                load_settings(directed_rows[k].sample, directed_rows[k].time_ms);
            end else begin
                send_req(directed_rows[k].sample, directed_rows[k].time_ms,
                         directed_rows[k].restart, hit, got);
                if (directed_rows[k].pinned) begin
                    pin.bpm         = directed_rows[k].pin_bpm;
                    pin.interval_ms = directed_rows[k].pin_interval;
                    if (hit != directed_rows[k].pin_beat || (hit && got != pin))
                        flag_mismatch($sformatf("table row %0d disagrees with predictor", k));
                    if (directed_rows[k].pin_beat) pending_beats.push_back(pin);
                end else if (hit) begin
                    pending_beats.push_back(got);
                end
            end
        end

        phase_thr = '{2000, 0, 4095, $urandom_range(0, 4000), $urandom_range(0, 4000),
                      $urandom_range(0, 4094)};
        phase_min = '{600, 0, 65535, $urandom_range(0, 2000), $urandom_range(0, 2000),
                      $urandom_range(0, 1500)};
        phase_len = '{280, 280, 50, 280, 280, 280};

        for (int p = 0; p < N_PHASES; p++) begin
            load_settings(t_sample'(phase_thr[p]), t_time'(phase_min[p]));
            // one phase runs with no idling on either side
            steady_flow = (p == 3);
            run_phase(phase_len[p]);
        end
        steady_flow = 1'b0;

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d samples (%0d restarts) over %0d register settings,",
                 n_requests, n_restarts, n_settings);
        $display("%0d rates checked, %0d mismatches", n_results, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- heartbeat_peak_rate_meter.f -----
rtl/hprm_pkg.sv
rtl/hprm_in_if.sv
rtl/hprm_out_if.sv
rtl/hprm_div.sv
rtl/heartbeat_peak_rate_meter.sv
rtl/hprm_checker.sv
verif/tb.sv
